@@ design/i2cm_pkg.sv @@
// Shared types and constants for the I2C master transfer sequencer.
// Depends on nothing; i2cm_cfg, i2cm_seq and i2c_master_transfer import it.
package i2cm_pkg;

  // One-hot bus sequencer phases
  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_START     = 13'b0000000000010,
    PH_TX_LOW    = 13'b0000000000100,
    PH_TX_HIGH   = 13'b0000000001000,
    PH_ACK_LOW   = 13'b0000000010000,
    PH_ACK_HIGH  = 13'b0000000100000,
    PH_RX_LOW    = 13'b0000001000000,
    PH_RX_HIGH   = 13'b0000010000000,
    PH_MACK_LOW  = 13'b0000100000000,
    PH_MACK_HIGH = 13'b0001000000000,
    PH_STOP_LOW  = 13'b0010000000000,
    PH_STOP_HIGH = 13'b0100000000000,
    PH_STOP_END  = 13'b1000000000000
  } phase_t;

  localparam int HALF_W     = 12;
  localparam int ACK_W      = 8;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_HALF_PERIOD = 1'b0;
  localparam reg_idx_t REG_ACK_TIMEOUT = 1'b1;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 12'd125;
  localparam logic [ACK_W-1:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [3:0]        BITS_PER_BYTE   = 4'd8;

  // One tick of input
  typedef struct packed {
    logic       go;
    logic [6:0] target_addr;
    logic       direction;
    logic [7:0] byte_count;
    logic [7:0] wr_byte;
    logic       sda_in;
  } item_t;

  // One tick of result
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       wr_take;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       done_res;
    logic       nack;
  } res_t;

endpackage

@@ design/i2cm_if.sv @@
// Handshake channel interfaces: tick input, tick result, configuration write.
// Depends on nothing beyond plain logic types.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic       go;
  logic [6:0] target_addr;
  logic       direction;
  logic [7:0] byte_count;
  logic [7:0] wr_byte;
  logic       sda_in;

  modport source (output valid, go, target_addr, direction, byte_count, wr_byte, sda_in,
                  input ready);
  modport sink   (input valid, go, target_addr, direction, byte_count, wr_byte, sda_in,
                  output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_oe;
  logic       busy_res;
  logic       wr_take;
  logic [7:0] rd_byte;
  logic       rd_valid;
  logic       done_res;
  logic       nack;

  modport source (output valid, scl, sda_out, sda_oe, busy_res, wr_take, rd_byte, rd_valid,
                  done_res, nack, input ready);
  modport sink   (input valid, scl, sda_out, sda_oe, busy_res, wr_take, rd_byte, rd_valid,
                  done_res, nack, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  reg_index;
  logic [11:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ design/i2cm_cfg.sv @@
// Configuration registers: SCL half period and ack timeout.
// Depends on i2cm_pkg and i2cm_cfg_if.
module i2cm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  i2cm_cfg_if.sink                      cfg,
  output logic [i2cm_pkg::HALF_W-1:0]   half_period,
  output logic [i2cm_pkg::ACK_W-1:0]    ack_timeout
);
  import i2cm_pkg::*;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_HALF_PERIOD: half_period <= cfg.wr_data[HALF_W-1:0];
        REG_ACK_TIMEOUT: ack_timeout <= cfg.wr_data[ACK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/i2cm_seq.sv @@
// Bus sequencer: phase, timers, shift register; one step per accepted tick.
// Result for the tick is combinational from state and input. Depends on i2cm_pkg.
module i2cm_seq #(
  parameter int TIMER_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  i2cm_pkg::item_t             item,
  input  logic [i2cm_pkg::HALF_W-1:0] half_period,
  input  logic [i2cm_pkg::ACK_W-1:0]  ack_timeout,
  output i2cm_pkg::res_t              res
);
  import i2cm_pkg::*;

  // Compare width covers both the timer plus one and the configured half period
  localparam int CW = (TIMER_BITS + 1 > HALF_W) ? TIMER_BITS + 1 : HALF_W;

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] tick_timer, tick_timer_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [7:0]            bytes_left, bytes_left_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic [7:0]            ack_wait, ack_wait_next;
  logic                  read_mode, read_mode_next;
  logic                  timed_out, timed_out_next;

  logic [CW-1:0] timer_inc, half_nz, half_lim, half_eff;
  logic          ph_end;
  logic          drv_scl, drv_sda, drv_oe;
  logic [7:0]    rx_shift;
  logic [3:0]    bit_inc;

  // End of a half phase: half period of zero acts as one, capped at timer range
  always_comb begin
    timer_inc = CW'(tick_timer) + CW'(1);
    half_nz   = (half_period == '0) ? CW'(1) : CW'(half_period);
    half_lim  = CW'(1) << TIMER_BITS;
    half_eff  = (half_nz > half_lim) ? half_lim : half_nz;
    ph_end    = (timer_inc >= half_eff);
  end

  assign rx_shift = (tick_timer == '0) ? {shift_reg[6:0], item.sda_in} : shift_reg;
  assign bit_inc  = bit_index + 4'd1;

  // Line drive from the current phase
  always_comb begin
    drv_scl = 1'b1;
    drv_sda = 1'b1;
    drv_oe  = 1'b0;
    unique case (phase)
      PH_START:     begin drv_oe = 1'b1; drv_sda = 1'b0; end
      PH_TX_LOW:    begin drv_scl = 1'b0; drv_oe = 1'b1; drv_sda = shift_reg[7]; end
      PH_TX_HIGH:   begin drv_oe = 1'b1; drv_sda = shift_reg[7]; end
      PH_ACK_LOW,
      PH_RX_LOW:    drv_scl = 1'b0;
      PH_MACK_LOW:  begin drv_scl = 1'b0; drv_oe = 1'b1; drv_sda = (bytes_left == '0); end
      PH_MACK_HIGH: begin drv_oe = 1'b1; drv_sda = (bytes_left == '0); end
      PH_STOP_LOW:  begin drv_scl = 1'b0; drv_oe = 1'b1; drv_sda = 1'b0; end
      PH_STOP_HIGH: begin drv_oe = 1'b1; drv_sda = 1'b0; end
      default: ;
    endcase
  end

  // Phase transitions and per-tick pulses
  always_comb begin
    phase_next      = phase;
    tick_timer_next = tick_timer;
    bit_index_next  = bit_index;
    bytes_left_next = bytes_left;
    shift_reg_next  = shift_reg;
    ack_wait_next   = ack_wait;
    read_mode_next  = read_mode;
    timed_out_next  = timed_out;

    res          = '0;
    res.scl      = drv_scl;
    res.sda_oe   = drv_oe;
    res.sda_out  = drv_oe ? drv_sda : 1'b1;
    res.busy_res = (phase != PH_IDLE);

    unique case (phase)
      PH_IDLE: begin
        if (item.go) begin
          shift_reg_next  = {item.target_addr, item.direction};
          read_mode_next  = item.direction;
          bytes_left_next = item.byte_count;
          bit_index_next  = '0;
          ack_wait_next   = '0;
          timed_out_next  = 1'b0;
          phase_next      = PH_START;
          tick_timer_next = '0;
        end
      end
      PH_START, PH_TX_LOW, PH_ACK_LOW, PH_RX_LOW, PH_MACK_LOW, PH_STOP_LOW,
      PH_STOP_HIGH: begin
        if (ph_end) begin
          tick_timer_next = '0;
          case (phase)
            PH_START:    phase_next = PH_TX_LOW;
            PH_TX_LOW:   phase_next = PH_TX_HIGH;
            PH_ACK_LOW:  phase_next = PH_ACK_HIGH;
            PH_RX_LOW:   phase_next = PH_RX_HIGH;
            PH_MACK_LOW: phase_next = PH_MACK_HIGH;
            PH_STOP_LOW: phase_next = PH_STOP_HIGH;
            default:     phase_next = PH_STOP_END;
          endcase
        end else begin
          tick_timer_next = timer_inc[TIMER_BITS-1:0];
        end
      end
      PH_TX_HIGH: begin
        if (ph_end) begin
          shift_reg_next  = {shift_reg[6:0], 1'b0};
          tick_timer_next = '0;
          if (bit_inc >= BITS_PER_BYTE) begin
            bit_index_next = '0;
            ack_wait_next  = '0;
            phase_next     = PH_ACK_LOW;
          end else begin
            bit_index_next = bit_inc;
            phase_next     = PH_TX_LOW;
          end
        end else begin
          tick_timer_next = timer_inc[TIMER_BITS-1:0];
        end
      end
      PH_ACK_HIGH: begin
        if (!item.sda_in) begin
          tick_timer_next = '0;
          if (bytes_left == '0) begin
            phase_next = PH_STOP_LOW;
          end else if (read_mode) begin
            shift_reg_next = '0;
            phase_next     = PH_RX_LOW;
          end else begin
            shift_reg_next  = item.wr_byte;
            res.wr_take     = 1'b1;
            bytes_left_next = bytes_left - 8'd1;
            phase_next      = PH_TX_LOW;
          end
        end else begin
          ack_wait_next = ack_wait + 8'd1;
          // Wrap to zero also counts as a timeout
          if (ack_wait_next >= ack_timeout || ack_wait_next == '0) begin
            timed_out_next  = 1'b1;
            phase_next      = PH_STOP_LOW;
            tick_timer_next = '0;
          end
        end
      end
      PH_RX_HIGH: begin
        shift_reg_next = rx_shift;
        if (ph_end) begin
          tick_timer_next = '0;
          if (bit_inc >= BITS_PER_BYTE) begin
            bit_index_next  = '0;
            res.rd_valid    = 1'b1;
            res.rd_byte     = rx_shift;
            bytes_left_next = bytes_left - 8'd1;
            phase_next      = PH_MACK_LOW;
          end else begin
            bit_index_next = bit_inc;
            phase_next     = PH_RX_LOW;
          end
        end else begin
          tick_timer_next = timer_inc[TIMER_BITS-1:0];
        end
      end
      PH_MACK_HIGH: begin
        if (ph_end) begin
          shift_reg_next  = '0;
          tick_timer_next = '0;
          phase_next      = (bytes_left == '0) ? PH_STOP_LOW : PH_RX_LOW;
        end else begin
          tick_timer_next = timer_inc[TIMER_BITS-1:0];
        end
      end
      PH_STOP_END: begin
        if (ph_end) begin
          res.done_res    = 1'b1;
          res.nack        = timed_out;
          timed_out_next  = 1'b0;
          tick_timer_next = '0;
          phase_next      = PH_IDLE;
        end else begin
          tick_timer_next = timer_inc[TIMER_BITS-1:0];
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_timer_next = '0;
      end
    endcase
  end

  // State update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_timer <= '0;
      bit_index  <= '0;
      bytes_left <= '0;
      shift_reg  <= '0;
      ack_wait   <= '0;
      read_mode  <= 1'b0;
      timed_out  <= 1'b0;
    end else if (adv) begin
      phase      <= phase_next;
      tick_timer <= tick_timer_next;
      bit_index  <= bit_index_next;
      bytes_left <= bytes_left_next;
      shift_reg  <= shift_reg_next;
      ack_wait   <= ack_wait_next;
      read_mode  <= read_mode_next;
      timed_out  <= timed_out_next;
    end
  end

  // Byte position never reaches a full byte between ticks
  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index < BITS_PER_BYTE)
    else $error("bit index out of range");

  // Half-phase timer rests at zero while idle and while waiting for the ack
  a_timer_rest: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE || phase == PH_ACK_HIGH) |-> tick_timer == '0)
    else $error("half-phase timer running outside a timed phase");

endmodule

@@ design/i2c_master_transfer.sv @@
// I2C master transfer: one tick item in, one result item out, every cycle
// while results are taken. The sequencer step lies between the input port and
// the result register, so a result is valid in the cycle after its tick transfer.
// A tick is taken whenever the result register is empty or being drained.
// Reset (synchronous, rst high): idle phase, SCL/SDA released, registers to
// half period 125 and ack timeout 250, no result pending.
// Depends on i2cm_pkg, i2cm_if, i2cm_cfg and i2cm_seq.
module i2c_master_transfer #(
  parameter int TIMER_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  i2cm_in_if.sink     items,
  i2cm_out_if.source  results,
  i2cm_cfg_if.sink    cfg
);
  import i2cm_pkg::*;

  logic [HALF_W-1:0]   half_period;
  logic [ACK_W-1:0]    ack_timeout;
  item_t               item;
  res_t                res, out_res;
  logic                out_valid;
  logic                item_acc;

  i2cm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .half_period (half_period),
    .ack_timeout (ack_timeout)
  );

  // Input handshake: output register empty or draining this cycle
  assign items.ready = !out_valid || results.ready;
  assign item_acc    = items.valid && items.ready;

  assign item.go          = items.go;
  assign item.target_addr = items.target_addr;
  assign item.direction   = items.direction;
  assign item.byte_count  = items.byte_count;
  assign item.wr_byte     = items.wr_byte;
  assign item.sda_in      = items.sda_in;

  i2cm_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .adv         (item_acc),
    .item        (item),
    .half_period (half_period),
    .ack_timeout (ack_timeout),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_acc) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      out_res <= res;
    end
  end

  assign results.valid    = out_valid;
  assign results.scl      = out_res.scl;
  assign results.sda_out  = out_res.sda_out;
  assign results.sda_oe   = out_res.sda_oe;
  assign results.busy_res = out_res.busy_res;
  assign results.wr_take  = out_res.wr_take;
  assign results.rd_byte  = out_res.rd_byte;
  assign results.rd_valid = out_res.rd_valid;
  assign results.done_res = out_res.done_res;
  assign results.nack     = out_res.nack;

  // Nack is only ever reported with the end of a transfer
  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.nack |-> out_res.done_res)
    else $error("nack without done");

  // A released SDA reads back high
  a_released_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.sda_oe |-> out_res.sda_out)
    else $error("released SDA not high");

  // Take, delivery and done pulses only while busy; take and delivery never share a tick
  a_pulse_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.wr_take || out_res.rd_valid || out_res.done_res)
      |-> out_res.busy_res && !(out_res.wr_take && out_res.rd_valid))
    else $error("pulse outside a transfer");

  // A stalled result keeps its contents until it is taken
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !results.ready |=> out_valid && $stable(out_res))
    else $error("pending result lost");

endmodule
